// File: rtl/core/toroidal_life_automaton_core_defines.svh
// Assertion macros for the toroidal life automaton core.
// Expects clk and rst_n in the scope of each use.
`ifndef TOROIDAL_LIFE_AUTOMATON_CORE_DEFINES_SVH
`define TOROIDAL_LIFE_AUTOMATON_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TLA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("toroidal life automaton check failed");

// Check that a condition never holds outside reset.
`define TLA_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("toroidal life automaton forbidden condition");

`endif

// File: rtl/core/tla_pkg.sv
// Shared types, constants and the neighbour count function of the life core.
// No dependencies.
`timescale 1ns / 1ps

package tla_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 32;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 5;
    localparam int NR_W     = ROW_W + 1;
    localparam int NC_W     = COL_W + 1;
    localparam int MASK_W   = 9;
    localparam int CNT_W    = 4;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_ADVANCE = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    localparam logic [1:0] REG_SURVIVE = 2'd0;
    localparam logic [1:0] REG_BIRTH   = 2'd1;
    localparam logic [1:0] REG_ROWS    = 2'd2;
    localparam logic [1:0] REG_COLS    = 2'd3;

    localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd12;
    localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'd8;
    localparam logic [NR_W-1:0]   ROWS_RESET    = 7'd50;
    localparam logic [NC_W-1:0]   COLS_RESET    = 6'd30;

    typedef logic [MAX_COLS-1:0] row_t;

    typedef struct packed {
        logic [MASK_W-1:0] survive;
        logic [MASK_W-1:0] birth;
        logic [NR_W-1:0]   nr;
        logic [NC_W-1:0]   nc;
    } cfg_t;

    function automatic logic [CNT_W-1:0] nb_count(
        input row_t             up_row,
        input row_t             mid_row,
        input row_t             dn_row,
        input logic [COL_W-1:0] c,
        input logic [NC_W-1:0]  nc
    );
        logic [COL_W-1:0] lf;
        logic [COL_W-1:0] rt;
        logic [NC_W-1:0]  c_inc;
        begin
            c_inc = {1'b0, c} + 1'b1;
            lf = (c == '0) ? COL_W'(nc - 1'b1) : c - 1'b1;
            rt = (c_inc >= nc) ? '0 : COL_W'(c_inc);
            nb_count = CNT_W'(up_row[lf]) + CNT_W'(up_row[c]) + CNT_W'(up_row[rt])
                     + CNT_W'(mid_row[lf]) + CNT_W'(mid_row[rt])
                     + CNT_W'(dn_row[lf]) + CNT_W'(dn_row[c]) + CNT_W'(dn_row[rt]);
        end
    endfunction

endpackage

// File: rtl/core/tla_cfg.sv
// APB register file: survive and birth masks, rows and columns in use.
// Depends on tla_pkg; hands clamped sizes to the core as a cfg_t.
`timescale 1ns / 1ps

module tla_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tla_pkg::PADDR_W-1:0]   paddr,
    input  logic [tla_pkg::PDATA_W-1:0]   pwdata,
    output logic [tla_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output tla_pkg::cfg_t                 cfg
);

    logic [tla_pkg::MASK_W-1:0] survive_reg;
    logic [tla_pkg::MASK_W-1:0] birth_reg;
    logic [tla_pkg::NR_W-1:0]   rows_reg;
    logic [tla_pkg::NC_W-1:0]   cols_reg;
    logic [1:0]                 reg_sel;
    logic                       wr_en;

    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            survive_reg <= tla_pkg::SURVIVE_RESET;
            birth_reg   <= tla_pkg::BIRTH_RESET;
            rows_reg    <= tla_pkg::ROWS_RESET;
            cols_reg    <= tla_pkg::COLS_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                tla_pkg::REG_SURVIVE: survive_reg <= pwdata[tla_pkg::MASK_W-1:0];
                tla_pkg::REG_BIRTH:   birth_reg   <= pwdata[tla_pkg::MASK_W-1:0];
                tla_pkg::REG_ROWS:    rows_reg    <= pwdata[tla_pkg::NR_W-1:0];
                tla_pkg::REG_COLS:    cols_reg    <= pwdata[tla_pkg::NC_W-1:0];
                default:              survive_reg <= survive_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            tla_pkg::REG_SURVIVE: prdata = tla_pkg::PDATA_W'(survive_reg);
            tla_pkg::REG_BIRTH:   prdata = tla_pkg::PDATA_W'(birth_reg);
            tla_pkg::REG_ROWS:    prdata = tla_pkg::PDATA_W'(rows_reg);
            tla_pkg::REG_COLS:    prdata = tla_pkg::PDATA_W'(cols_reg);
            default:              prdata = '0;
        endcase
    end

    // clamp sizes into 1..MAX
    always_comb
    begin
        cfg.survive = survive_reg;
        cfg.birth   = birth_reg;
        if (rows_reg == '0)
            cfg.nr = tla_pkg::NR_W'(1);
        else if (rows_reg > tla_pkg::NR_W'(tla_pkg::MAX_ROWS))
            cfg.nr = tla_pkg::NR_W'(tla_pkg::MAX_ROWS);
        else
            cfg.nr = rows_reg;
        if (cols_reg == '0)
            cfg.nc = tla_pkg::NC_W'(1);
        else if (cols_reg > tla_pkg::NC_W'(tla_pkg::MAX_COLS))
            cfg.nc = tla_pkg::NC_W'(tla_pkg::MAX_COLS);
        else
            cfg.nc = cols_reg;
    end

endmodule

// File: rtl/core/tla_row_mem.sv
// Grid memory: one row of cells per entry, one write and one read port.
// Depends on tla_pkg; per-row valid bits make unwritten rows read as dead.
`timescale 1ns / 1ps

module tla_row_mem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        we,
    input  logic [tla_pkg::ROW_W-1:0]   waddr,
    input  tla_pkg::row_t               wdata,
    input  logic                        re,
    input  logic [tla_pkg::ROW_W-1:0]   raddr,
    output tla_pkg::row_t               rdata
);

    tla_pkg::row_t                mem [tla_pkg::MAX_ROWS];
    tla_pkg::row_t                rdata_reg;
    logic [tla_pkg::MAX_ROWS-1:0] valid_reg;
    logic                         rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
                valid_reg[waddr] <= 1'b1;
            if (re)
                rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

// File: rtl/core/tla_row_update.sv
// Next-generation row from the old rows above, at and below it.
// Depends on tla_pkg; columns past the used width keep their value.
`timescale 1ns / 1ps

module tla_row_update (
    input  tla_pkg::cfg_t   cfg,
    input  tla_pkg::row_t   up_row,
    input  tla_pkg::row_t   mid_row,
    input  tla_pkg::row_t   dn_row,
    output tla_pkg::row_t   new_row
);

    always_comb
    begin
        logic [tla_pkg::CNT_W-1:0]  k;
        logic [tla_pkg::MASK_W-1:0] rule;
        new_row = mid_row;
        for (int c = 0; c < tla_pkg::MAX_COLS; c++)
        begin
            k = tla_pkg::nb_count(up_row, mid_row, dn_row, tla_pkg::COL_W'(c), cfg.nc);
            rule = mid_row[c] ? cfg.survive : cfg.birth;
            if (tla_pkg::NC_W'(c) < cfg.nc)
                new_row[c] = rule[k];
        end
    end

endmodule

// File: rtl/core/toroidal_life_automaton_core.sv
// Top level of the toroidal life automaton: request sequencer and result register.
// Depends on tla_pkg, tla_cfg, tla_row_mem, tla_row_update and the defines header.
//
//  channel | signals                                   | role
//  in      | in_valid/in_ready, req_type row col cell_in | write, advance or read
//  out     | out_valid/out_ready, read_row read_col      | one item per read
//          | cell_out neighbour_count                    |
//  apb     | psel penable pwrite paddr pwdata prdata     | registers at 4*index
//
// Write: reads the row, merges the bit and writes it back; a write outside the used grid is dropped.
// Read: fetches the rows above, at and below through the one read port.
// Advance: reads the last, first and second rows, then the sweep writes one grid row per cycle.
// Reset marks every row invalid at once, so the grid reads dead with no clearing pass.
// A read waits in its last cycle while the output register holds an item not yet taken.
`timescale 1ns / 1ps
`include "toroidal_life_automaton_core_defines.svh"

module toroidal_life_automaton_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic [tla_pkg::ROW_W-1:0]     row,
    input  logic [tla_pkg::COL_W-1:0]     col,
    input  logic                          cell_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tla_pkg::ROW_W-1:0]     read_row,
    output logic [tla_pkg::COL_W-1:0]     read_col,
    output logic                          cell_out,
    output logic [tla_pkg::CNT_W-1:0]     neighbour_count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tla_pkg::PADDR_W-1:0]   paddr,
    input  logic [tla_pkg::PDATA_W-1:0]   pwdata,
    output logic [tla_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_WR_RD    = 4'd1;
    localparam logic [3:0] S_WR_WB    = 4'd2;
    localparam logic [3:0] S_RD_UP    = 4'd3;
    localparam logic [3:0] S_RD_MID   = 4'd4;
    localparam logic [3:0] S_RD_DN    = 4'd5;
    localparam logic [3:0] S_RD_CAP   = 4'd6;
    localparam logic [3:0] S_RD_OUT   = 4'd7;
    localparam logic [3:0] S_AV_LAST  = 4'd8;
    localparam logic [3:0] S_AV_FIRST = 4'd9;
    localparam logic [3:0] S_AV_SEC   = 4'd10;
    localparam logic [3:0] S_AV_ROW   = 4'd11;

    tla_pkg::cfg_t cfg;

    logic [3:0]                  state_reg, state_next;
    logic [tla_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [tla_pkg::COL_W-1:0]   col_reg, col_next;
    logic                        cell_reg, cell_next;
    logic                        outside_reg, outside_next;
    logic [tla_pkg::ROW_W-1:0]   cnt_reg, cnt_next;
    tla_pkg::row_t               prev_reg, prev_next;
    tla_pkg::row_t               cur_reg, cur_next;
    tla_pkg::row_t               nxt_reg, nxt_next;
    tla_pkg::row_t               first_reg, first_next;

    logic                        out_valid_reg, out_valid_next;
    logic [tla_pkg::ROW_W-1:0]   read_row_reg, read_row_next;
    logic [tla_pkg::COL_W-1:0]   read_col_reg, read_col_next;
    logic                        cell_out_reg, cell_out_next;
    logic [tla_pkg::CNT_W-1:0]   count_reg, count_next;

    logic                        mem_we;
    logic [tla_pkg::ROW_W-1:0]   mem_waddr;
    tla_pkg::row_t               mem_wdata;
    logic                        mem_re;
    logic [tla_pkg::ROW_W-1:0]   mem_raddr;
    tla_pkg::row_t               mem_rdata;

    tla_pkg::row_t               sweep_dn;
    tla_pkg::row_t               sweep_row;
    tla_pkg::row_t               merged_row;
    logic [tla_pkg::NR_W-1:0]    cnt_inc;
    logic [tla_pkg::NR_W-1:0]    row_inc;
    logic [tla_pkg::ROW_W-1:0]   up_addr;
    logic [tla_pkg::ROW_W-1:0]   dn_addr;
    logic                        in_range;
    logic                        in_fire;

    tla_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tla_row_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tla_row_update u_update (
        .cfg     (cfg),
        .up_row  (prev_reg),
        .mid_row (cur_reg),
        .dn_row  (sweep_dn),
        .new_row (sweep_row)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign in_range = ({1'b0, row} < cfg.nr) && ({1'b0, col} < cfg.nc);

    assign cnt_inc  = {1'b0, cnt_reg} + 1'b1;
    assign row_inc  = {1'b0, row_reg} + 1'b1;
    assign up_addr  = (row_reg == '0) ? tla_pkg::ROW_W'(cfg.nr - 1'b1) : row_reg - 1'b1;
    assign dn_addr  = (row_inc >= cfg.nr) ? '0 : tla_pkg::ROW_W'(row_inc);
    // the last row wraps onto row zero, already rewritten: use its saved copy
    assign sweep_dn = (cnt_inc >= cfg.nr) ? first_reg : mem_rdata;

    always_comb
    begin
        merged_row = mem_rdata;
        merged_row[col_reg] = cell_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cell_next      = cell_reg;
        outside_next   = outside_reg;
        cnt_next       = cnt_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !out_ready;
        read_row_next  = read_row_reg;
        read_col_next  = read_col_reg;
        cell_out_next  = cell_out_reg;
        count_next     = count_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg;
        mem_wdata      = sweep_row;
        mem_re         = 1'b0;
        mem_raddr      = row_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    row_next     = row;
                    col_next     = col;
                    cell_next    = cell_in;
                    outside_next = !in_range;
                    case (req_type)
                        tla_pkg::REQ_WRITE:
                            if (in_range)
                                state_next = S_WR_RD;
                        tla_pkg::REQ_ADVANCE:
                            state_next = S_AV_LAST;
                        tla_pkg::REQ_READ:
                            state_next = in_range ? S_RD_UP : S_RD_OUT;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_WR_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = row_reg;
                state_next = S_WR_WB;
            end
            S_WR_WB:
            begin
                mem_we     = 1'b1;
                mem_waddr  = row_reg;
                mem_wdata  = merged_row;
                state_next = S_IDLE;
            end
            S_RD_UP:
            begin
                mem_re     = 1'b1;
                mem_raddr  = up_addr;
                state_next = S_RD_MID;
            end
            S_RD_MID:
            begin
                prev_next  = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = row_reg;
                state_next = S_RD_DN;
            end
            S_RD_DN:
            begin
                cur_next   = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = dn_addr;
                state_next = S_RD_CAP;
            end
            S_RD_CAP:
            begin
                nxt_next   = mem_rdata;
                state_next = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    read_row_next  = row_reg;
                    read_col_next  = col_reg;
                    if (outside_reg)
                    begin
                        cell_out_next = 1'b0;
                        count_next    = '0;
                    end
                    else
                    begin
                        cell_out_next = cur_reg[col_reg];
                        count_next    = tla_pkg::nb_count(prev_reg, cur_reg, nxt_reg,
                                                          col_reg, cfg.nc);
                    end
                    state_next = S_IDLE;
                end
            end
            S_AV_LAST:
            begin
                mem_re     = 1'b1;
                mem_raddr  = tla_pkg::ROW_W'(cfg.nr - 1'b1);
                state_next = S_AV_FIRST;
            end
            S_AV_FIRST:
            begin
                prev_next  = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = S_AV_SEC;
            end
            S_AV_SEC:
            begin
                cur_next   = mem_rdata;
                first_next = mem_rdata;
                cnt_next   = '0;
                mem_re     = 1'b1;
                mem_raddr  = tla_pkg::ROW_W'(1);
                state_next = S_AV_ROW;
            end
            S_AV_ROW:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cnt_reg;
                mem_wdata  = sweep_row;
                mem_re     = 1'b1;
                mem_raddr  = cnt_reg + tla_pkg::ROW_W'(2);
                prev_next  = cur_reg;
                cur_next   = sweep_dn;
                cnt_next   = tla_pkg::ROW_W'(cnt_inc);
                if (cnt_inc >= cfg.nr)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        cell_reg     <= cell_next;
        outside_reg  <= outside_next;
        cnt_reg      <= cnt_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        first_reg    <= first_next;
        read_row_reg <= read_row_next;
        read_col_reg <= read_col_next;
        cell_out_reg <= cell_out_next;
        count_reg    <= count_next;
    end

    assign out_valid       = out_valid_reg;
    assign read_row        = read_row_reg;
    assign read_col        = read_col_reg;
    assign cell_out        = cell_out_reg;
    assign neighbour_count = count_reg;

    `TLA_ASSERT(a_we_states, mem_we |-> (state_reg == S_WR_WB || state_reg == S_AV_ROW))
    `TLA_NEVER(a_no_same_row, mem_we && mem_re && (mem_waddr == mem_raddr))
    `TLA_ASSERT(a_out_from_read, $rose(out_valid_reg) |-> $past(state_reg) == S_RD_OUT)
    `TLA_ASSERT(a_sweep_exit, (state_reg == S_AV_ROW) |=>
                (state_reg == S_AV_ROW || state_reg == S_IDLE))

endmodule
